### design/yuvhsl_pkg.sv
// Shared types and constants for the YUV to HSL pixel converter.
package yuvhsl_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUMA_OFFSET    = 3'd0,
        REG_CHROMA_OFFSET  = 3'd1,
        REG_LUMA_WEIGHT    = 3'd2,
        REG_U_BLUE_WEIGHT  = 3'd3,
        REG_U_GREEN_WEIGHT = 3'd4,
        REG_V_GREEN_WEIGHT = 3'd5,
        REG_V_RED_WEIGHT   = 3'd6
    } cfg_idx_t;

    localparam logic [7:0]  LUMA_OFFSET_RST    = 8'd16;
    localparam logic [7:0]  CHROMA_OFFSET_RST  = 8'd128;
    localparam logic signed [15:0] LUMA_WEIGHT_RST    = 16'sd9535;
    localparam logic signed [15:0] U_BLUE_WEIGHT_RST  = 16'sd16532;
    localparam logic signed [15:0] U_GREEN_WEIGHT_RST = -16'sd3203;
    localparam logic signed [15:0] V_GREEN_WEIGHT_RST = -16'sd6660;
    localparam logic signed [15:0] V_RED_WEIGHT_RST   = 16'sd13075;

    // Divider: 20-bit dividend, 9-bit divisor, quotient bits per stage.
    localparam int DIV_N = 20;
    localparam int DIV_D = 9;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BPS = DIV_N / DIV_STAGES;

    typedef struct packed {
        logic       gray;
        logic [7:0] light;
    } side_t;

endpackage

### design/yuvhsl_div.sv
// Pipelined restoring divider, DIV_BPS (five) quotient bits per stage, with stall support.
module yuvhsl_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [yuvhsl_pkg::DIV_N-1:0] dividend,
    input  logic [yuvhsl_pkg::DIV_D-1:0] divisor,
    input  yuvhsl_pkg::side_t            side_in,
    output logic                         out_valid,
    output logic [yuvhsl_pkg::DIV_N-1:0] quotient,
    output yuvhsl_pkg::side_t            side_out
);
    import yuvhsl_pkg::*;

    logic                            vld_reg [1:DIV_STAGES];
    logic [DIV_N-1:0]                q_reg   [1:DIV_STAGES];
    logic [DIV_D-1:0]                rem_reg [1:DIV_STAGES];
    logic [DIV_D-1:0]                den_reg [1:DIV_STAGES];
    side_t                           sd_reg  [1:DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic             vld_in;
        logic [DIV_N-1:0] q_in;
        logic [DIV_D-1:0] rem_in;
        logic [DIV_D-1:0] den_in;
        side_t            sd_in;
        logic [DIV_N-1:0] q_next;
        logic [DIV_D-1:0] rem_next;

        if (s == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign q_in   = dividend;
            assign rem_in = '0;
            assign den_in = divisor;
            assign sd_in  = side_in;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[s];
            assign q_in   = q_reg[s];
            assign rem_in = rem_reg[s];
            assign den_in = den_reg[s];
            assign sd_in  = sd_reg[s];
        end

        always_comb
        begin
            logic [DIV_D:0]   r;
            logic [DIV_N-1:0] q;
            logic [DIV_D-1:0] rm;
            q  = q_in;
            rm = rem_in;
            r  = '0;
            for (int b = 0; b < DIV_BPS; b++)
            begin
                r = {rm, q[DIV_N-1]};
                q = {q[DIV_N-2:0], 1'b0};
                if (r >= {1'b0, den_in})
                begin
                    r = r - {1'b0, den_in};
                    q[0] = 1'b1;
                end
                rm = r[DIV_D-1:0];
            end
            q_next   = q;
            rem_next = rm;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s+1]   <= q_next;
                rem_reg[s+1] <= rem_next;
                den_reg[s+1] <= den_in;
                sd_reg[s+1]  <= sd_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES];
    assign quotient  = q_reg[DIV_STAGES];
    assign side_out  = sd_reg[DIV_STAGES];

endmodule

### design/yuv_to_hsl_pixel_converter.sv
// Top level of the YUV 4:4:4 to HSL pixel converter.
//
// One YUV word enters on s_axis_* and one HSL word leaves on m_axis_*.
// Each word passes a fixed pipeline: offset subtract, weight multiply,
// matrix sum and clamp, max/min, dividend build, two dividers of four
// stages each, and an output register: ten register stages. A new
// word can be taken every cycle unless the output word is held, so
// throughput is one word per clock; the divider depth is DIV_STAGES.
// The configuration port writes one register per cycle by index and must
// be used only while the pipeline is empty.
// Reset clears all valid bits and loads the default BT.601 coefficients.
// When the receiver drops m_axis_tready with the output register full,
// the whole pipeline holds; s_axis_tready falls only in that case, and
// no word is lost or repeated.
module yuv_to_hsl_pixel_converter #(
    parameter int FRAC_SHIFT = 13
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [yuvhsl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yuvhsl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [23:0]                        s_axis_tdata,  // y_in, u_in, v_in
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [23:0]                        m_axis_tdata   // hue, saturation, lightness
);
    import yuvhsl_pkg::*;

    localparam int ACC_W = 36;

    logic [7:0]         luma_off_reg, chroma_off_reg;
    logic signed [15:0] w_luma_reg, w_ub_reg, w_ug_reg, w_vg_reg, w_vr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_off_reg   <= LUMA_OFFSET_RST;
            chroma_off_reg <= CHROMA_OFFSET_RST;
            w_luma_reg     <= LUMA_WEIGHT_RST;
            w_ub_reg       <= U_BLUE_WEIGHT_RST;
            w_ug_reg       <= U_GREEN_WEIGHT_RST;
            w_vg_reg       <= V_GREEN_WEIGHT_RST;
            w_vr_reg       <= V_RED_WEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_LUMA_OFFSET:    luma_off_reg   <= cfg_data[7:0];
                REG_CHROMA_OFFSET:  chroma_off_reg <= cfg_data[7:0];
                REG_LUMA_WEIGHT:    w_luma_reg     <= cfg_data;
                REG_U_BLUE_WEIGHT:  w_ub_reg       <= cfg_data;
                REG_U_GREEN_WEIGHT: w_ug_reg       <= cfg_data;
                REG_V_GREEN_WEIGHT: w_vg_reg       <= cfg_data;
                REG_V_RED_WEIGHT:   w_vr_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global enable: pipeline advances unless the output word is held.
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: offset subtract.
    logic               v1_reg;
    logic signed [8:0]  y1_reg, u1_reg, vv1_reg;
    // Stage 2: products.
    logic               v2_reg;
    logic signed [24:0] ly2_reg, vr2_reg, ug2_reg, vg2_reg, ub2_reg;
    // Stage 3: clamped channels.
    logic               v3_reg;
    logic [7:0]         r3_reg, g3_reg, b3_reg;
    // Stage 4: max/min.
    logic               v4_reg;
    logic [7:0]         r4_reg, g4_reg, b4_reg, mx4_reg, mn4_reg;
    // Stage 5: dividends and divisors.
    logic               v5_reg;
    logic [DIV_N-1:0]   hnum5_reg, snum5_reg;
    logic [8:0]         hden5_reg, sden5_reg;
    side_t              sd5_reg;

    function automatic logic [7:0] clamp_ch(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        q = (acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (q < 0)
            return 8'd0;
        else if (q > 255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

    logic [7:0] mx_c, mn_c;
    logic [8:0] rng_c, sum_c, den_c;
    logic [10:0] d_c;

    always_comb
    begin
        mx_c = r3_reg;
        mn_c = r3_reg;
        if (g3_reg > mx_c) mx_c = g3_reg;
        if (b3_reg > mx_c) mx_c = b3_reg;
        if (g3_reg < mn_c) mn_c = g3_reg;
        if (b3_reg < mn_c) mn_c = b3_reg;
    end

    always_comb
    begin
        rng_c = {1'b0, mx4_reg} - {1'b0, mn4_reg};
        sum_c = {1'b0, mx4_reg} + {1'b0, mn4_reg};
        if (r4_reg == mx4_reg)
            d_c = 11'({3'b0, g4_reg}) - 11'({3'b0, b4_reg}) + 11'(6 * rng_c);
        else if (g4_reg == mx4_reg)
            d_c = 11'({3'b0, b4_reg}) - 11'({3'b0, r4_reg}) + 11'(2 * rng_c);
        else
            d_c = 11'({3'b0, r4_reg}) - 11'({3'b0, g4_reg}) + 11'(4 * rng_c);
        den_c = (sum_c < 9'd510 - sum_c) ? sum_c : 9'd510 - sum_c;
        if (den_c == 9'd0)
            den_c = 9'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg  <= $signed({1'b0, s_axis_tdata[7:0]})   - $signed({1'b0, luma_off_reg});
            u1_reg  <= $signed({1'b0, s_axis_tdata[15:8]})  - $signed({1'b0, chroma_off_reg});
            vv1_reg <= $signed({1'b0, s_axis_tdata[23:16]}) - $signed({1'b0, chroma_off_reg});
            ly2_reg <= y1_reg * w_luma_reg;
            vr2_reg <= vv1_reg * w_vr_reg;
            ug2_reg <= u1_reg * w_ug_reg;
            vg2_reg <= vv1_reg * w_vg_reg;
            ub2_reg <= u1_reg * w_ub_reg;
            r3_reg  <= clamp_ch(ACC_W'(ly2_reg) + ACC_W'(vr2_reg));
            g3_reg  <= clamp_ch(ACC_W'(ly2_reg) + ACC_W'(ug2_reg) + ACC_W'(vg2_reg));
            b3_reg  <= clamp_ch(ACC_W'(ly2_reg) + ACC_W'(ub2_reg));
            r4_reg  <= r3_reg;
            g4_reg  <= g3_reg;
            b4_reg  <= b3_reg;
            mx4_reg <= mx_c;
            mn4_reg <= mn_c;
            hnum5_reg   <= DIV_N'(d_c) * DIV_N'(7'd85);
            hden5_reg   <= {rng_c[7:0], 1'b0};
            snum5_reg   <= DIV_N'(rng_c) * DIV_N'(8'd255);
            sden5_reg   <= den_c;
            sd5_reg.gray  <= (rng_c == 9'd0);
            sd5_reg.light <= sum_c[8:1];
        end
    end

    logic             hv, sv;
    logic [DIV_N-1:0] hq, sq;
    side_t            hsd, ssd;

    yuvhsl_div u_hue_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .dividend(hnum5_reg), .divisor(hden5_reg), .side_in(sd5_reg),
        .out_valid(hv), .quotient(hq), .side_out(hsd)
    );

    yuvhsl_div u_sat_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .dividend(snum5_reg), .divisor(sden5_reg), .side_in(sd5_reg),
        .out_valid(sv), .quotient(sq), .side_out(ssd)
    );

    logic       out_v_reg;
    logic [23:0] out_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= hv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_d_reg[7:0]   <= hsd.gray ? 8'd0 : hq[7:0];
            out_d_reg[15:8]  <= ssd.gray ? 8'd0 : ((sq > DIV_N'(255)) ? 8'd255 : sq[7:0]);
            out_d_reg[23:16] <= hsd.light;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n) hv == sv)
        else $error("Divider valid bits diverged.");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output word changed under stall.");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input blocked with empty output.");

endmodule
